// ===== hw/rtl/set_assoc_cache_lru_2q_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative cache unit
// Shared forms for implication checks on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_2Q_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_2Q_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define SACL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sacl check failed");

// Next-cycle implication, disabled while reset is active.
`define SACL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sacl check failed");

`endif

// ===== hw/rtl/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Constants, codes and shared types of the set-associative cache unit.
// ----------------------------------------------------------------------------
`default_nettype none
package sacl_pkg;

  localparam int MAX_SET_BITS = 8;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_WIDTH   = 64;
  localparam int AGE_WIDTH    = 32;

  localparam int TOTAL_W      = 32;
  localparam int SET_BITS_W   = 4;
  localparam int BLOCK_BITS_W = 5;
  localparam int WAYS_W       = 4;
  localparam int CFG_DATA_W   = 5;
  localparam int CFG_IDX_W    = 2;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 4'd4;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS_USED  = 2'd2,
    CFG_POLICY     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_MODIFY = 2'd2,
    MODE_IFETCH = 2'd3
  } mode_t;

  // Outcome of the set search, handed from the search unit to the updater.
  typedef struct packed {
    logic hit;
    logic have_empty;
    logic fifo_hit;
  } search_flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sacl_ram.sv =====
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/sacl_search.sv =====
// ----------------------------------------------------------------------------
// sacl_search
// Searches one set row: tag hit, first empty way, oldest way, and the
// recent-tag queue; registers the outcome for the update step.
// ----------------------------------------------------------------------------
`default_nettype none
module sacl_search #(
  parameter int MAX_WAYS   = sacl_pkg::MAX_WAYS,
  parameter int ADDR_WIDTH = sacl_pkg::ADDR_WIDTH,
  parameter int AGE_WIDTH  = sacl_pkg::AGE_WIDTH,
  localparam int WAY_IW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int CNT_W     = $clog2(MAX_WAYS + 1)
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ADDR_WIDTH-1:0]       tag,
  input  logic [CNT_W-1:0]            ways,
  input  logic [MAX_WAYS-1:0]         valid,
  input  logic [ADDR_WIDTH-1:0]       tags  [MAX_WAYS],
  input  logic [AGE_WIDTH-1:0]        ages  [MAX_WAYS],
  input  logic [ADDR_WIDTH-1:0]       rtags [MAX_WAYS],
  input  logic [CNT_W-1:0]            rcount,
  output sacl_pkg::search_flags_t     flags,
  output logic [WAY_IW-1:0]           hit_way,
  output logic [WAY_IW-1:0]           empty_way,
  output logic [WAY_IW-1:0]           old_way,
  output logic [WAY_IW-1:0]           fifo_idx
);

  sacl_pkg::search_flags_t flags_nxt, flags_r;
  logic [WAY_IW-1:0] hit_way_nxt, empty_way_nxt, old_way_nxt, fifo_idx_nxt;
  logic [WAY_IW-1:0] hit_way_r, empty_way_r, old_way_r, fifo_idx_r;

  always_comb begin
    flags_nxt     = '0;
    hit_way_nxt   = '0;
    empty_way_nxt = '0;
    old_way_nxt   = '0;
    fifo_idx_nxt  = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i < int'(ways)) begin
        if (!flags_nxt.hit && valid[i] && tags[i] == tag) begin
          flags_nxt.hit = 1'b1;
          hit_way_nxt   = WAY_IW'(i);
        end
        if (!flags_nxt.have_empty && !valid[i]) begin
          flags_nxt.have_empty = 1'b1;
          empty_way_nxt        = WAY_IW'(i);
        end
        // Strictly greater, so the lowest way keeps a tie.
        if (i > 0 && ages[i] > ages[old_way_nxt]) begin
          old_way_nxt = WAY_IW'(i);
        end
      end
      if (!flags_nxt.fifo_hit && i < int'(rcount) && rtags[i] == tag) begin
        flags_nxt.fifo_hit = 1'b1;
        fifo_idx_nxt       = WAY_IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r     <= flags_nxt;
      hit_way_r   <= hit_way_nxt;
      empty_way_r <= empty_way_nxt;
      old_way_r   <= old_way_nxt;
      fifo_idx_r  <= fifo_idx_nxt;
    end
  end

  assign flags     = flags_r;
  assign hit_way   = hit_way_r;
  assign empty_way = empty_way_r;
  assign old_way   = old_way_r;
  assign fifo_idx  = fifo_idx_r;

endmodule
`default_nettype wire

// ===== hw/rtl/set_assoc_cache_lru_2q_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_2q_unit
// Set-associative cache model with LRU replacement and optional 2Q admission.
//
//   Channel | Direction | Beat
//   in_     | input     | mode, address
//   out_    | output    | hits_added, missed, evicted, three running totals
//   cfg_    | input     | register write (index, data), no handshake
//
// A data access passes through set row read, search and row write-back. The
// set memory has one read and one write port and holds one row per set.
// An instruction fetch is accepted and produces no beat.
// After reset a clearing pass writes every row; in_ready stays low meanwhile.
// A result that has not left holds the write-back step of the next access,
// and in_ready stays low until that write-back is done.
// ----------------------------------------------------------------------------
`default_nettype none
module set_assoc_cache_lru_2q_unit #(
  parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS,
  parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS,
  parameter int ADDR_WIDTH   = sacl_pkg::ADDR_WIDTH,
  parameter int AGE_WIDTH    = sacl_pkg::AGE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic [ADDR_WIDTH-1:0]             in_address,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_hits_added,
  output logic                              out_missed,
  output logic                              out_evicted,
  output logic [sacl_pkg::TOTAL_W-1:0]      out_total_hits,
  output logic [sacl_pkg::TOTAL_W-1:0]      out_total_misses,
  output logic [sacl_pkg::TOTAL_W-1:0]      out_total_evictions,
  input  logic                              cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DEPTH   = 1 << MAX_SET_BITS;
  localparam int SET_AW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_IW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W   = $clog2(MAX_WAYS + 1);
  localparam int TAG_LO  = MAX_WAYS;
  localparam int AGE_LO  = TAG_LO + MAX_WAYS * ADDR_WIDTH;
  localparam int RTAG_LO = AGE_LO + MAX_WAYS * AGE_WIDTH;
  localparam int CNT_LO  = RTAG_LO + MAX_WAYS * ADDR_WIDTH;
  localparam int ROW_W   = CNT_LO + CNT_W;
  localparam int TW      = sacl_pkg::TOTAL_W;
  localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

  typedef enum logic [1:0] {ST_CLR, ST_IDLE, ST_CMP, ST_UPD} state_t;

  state_t state_r;
  logic [SET_AW-1:0] clr_idx_r;

  logic [sacl_pkg::SET_BITS_W-1:0]   set_bits_r;
  logic [sacl_pkg::BLOCK_BITS_W-1:0] block_bits_r;
  logic [sacl_pkg::WAYS_W-1:0]       ways_used_r;
  logic                              policy_r;

  logic [1:0]            mode_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic [SET_AW-1:0]     set_r;

  logic                  out_valid_r;
  logic [1:0]            hits_added_r;
  logic                  missed_r, evicted_r;
  logic [TW-1:0]         total_hits_r, total_misses_r, total_evicts_r;

  // --------------------------------------------------------------------------
  // Configuration and address split
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= sacl_pkg::SET_BITS_RST;
      block_bits_r <= sacl_pkg::BLOCK_BITS_RST;
      ways_used_r  <= sacl_pkg::WAYS_RST;
      policy_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (sacl_pkg::cfg_idx_t'(cfg_index))
        sacl_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_wdata[sacl_pkg::SET_BITS_W-1:0];
        sacl_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_wdata;
        sacl_pkg::CFG_WAYS_USED:  ways_used_r  <= cfg_wdata[sacl_pkg::WAYS_W-1:0];
        sacl_pkg::CFG_POLICY:     policy_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [4:0]            sb_eff;
  logic [CNT_W-1:0]      ways_eff;
  logic [5:0]            tag_shift;
  logic [ADDR_WIDTH-1:0] in_tag;
  logic [ADDR_WIDTH-1:0] set_shifted;
  logic [SET_AW-1:0]     set_mask, in_set;

  always_comb begin
    if (int'(set_bits_r) > MAX_SET_BITS) begin
      sb_eff = 5'(MAX_SET_BITS);
    end else begin
      sb_eff = 5'(set_bits_r);
    end
    if (ways_used_r == '0) begin
      ways_eff = CNT_W'(1);
    end else if (int'(ways_used_r) > MAX_WAYS) begin
      ways_eff = CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = CNT_W'(ways_used_r);
    end
    tag_shift   = 6'(block_bits_r) + 6'(sb_eff);
    in_tag      = in_address >> tag_shift;
    set_shifted = in_address >> block_bits_r;
    set_mask    = ~({SET_AW{1'b1}} << sb_eff);
    in_set      = set_shifted[SET_AW-1:0] & set_mask;
  end

  // --------------------------------------------------------------------------
  // Set memory
  // --------------------------------------------------------------------------
  logic              accept;
  logic              ram_we;
  logic [SET_AW-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata, new_row, rd_row;
  logic              upd_go;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign upd_go    = (state_r == ST_UPD) && (!out_valid_r || out_ready);
  assign ram_we    = (state_r == ST_CLR) || upd_go;
  assign ram_waddr = (state_r == ST_CLR) ? clr_idx_r : set_r;
  assign ram_wdata = (state_r == ST_CLR) ? '0 : new_row;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (1 << SET_AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_set),
    .rdata (rd_row)
  );

  logic [MAX_WAYS-1:0]   r_valid;
  logic [ADDR_WIDTH-1:0] r_tag  [MAX_WAYS];
  logic [AGE_WIDTH-1:0]  r_age  [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] r_rtag [MAX_WAYS];
  logic [CNT_W-1:0]      r_cnt;

  always_comb begin
    r_valid = rd_row[MAX_WAYS-1:0];
    r_cnt   = rd_row[CNT_LO +: CNT_W];
    for (int i = 0; i < MAX_WAYS; i++) begin
      r_tag[i]  = rd_row[TAG_LO + i * ADDR_WIDTH +: ADDR_WIDTH];
      r_age[i]  = rd_row[AGE_LO + i * AGE_WIDTH +: AGE_WIDTH];
      r_rtag[i] = rd_row[RTAG_LO + i * ADDR_WIDTH +: ADDR_WIDTH];
    end
  end

  // --------------------------------------------------------------------------
  // Search
  // --------------------------------------------------------------------------
  sacl_pkg::search_flags_t flags;
  logic [WAY_IW-1:0] hit_way, empty_way, old_way, fifo_idx;

  sacl_search #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .AGE_WIDTH  (AGE_WIDTH)
  ) u_search (
    .clk       (clk),
    .en        (state_r == ST_CMP),
    .tag       (tag_r),
    .ways      (ways_eff),
    .valid     (r_valid),
    .tags      (r_tag),
    .ages      (r_age),
    .rtags     (r_rtag),
    .rcount    (r_cnt),
    .flags     (flags),
    .hit_way   (hit_way),
    .empty_way (empty_way),
    .old_way   (old_way),
    .fifo_idx  (fifo_idx)
  );

  // --------------------------------------------------------------------------
  // Row update
  // --------------------------------------------------------------------------
  logic                  admit, do_touch, evict;
  logic [WAY_IW-1:0]     touch_way;
  logic [CNT_W-1:0]      q_n;
  logic [MAX_WAYS-1:0]   n_valid;
  logic [ADDR_WIDTH-1:0] n_tag  [MAX_WAYS];
  logic [AGE_WIDTH-1:0]  n_age  [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] n_rtag [MAX_WAYS];
  logic [CNT_W-1:0]      n_cnt;
  logic [1:0]            hits_now;

  always_comb begin
    admit     = !policy_r || flags.fifo_hit;
    evict     = !flags.hit && admit && !flags.have_empty;
    do_touch  = flags.hit || admit;
    if (flags.hit) begin
      touch_way = hit_way;
    end else if (flags.have_empty) begin
      touch_way = empty_way;
    end else begin
      touch_way = old_way;
    end
    q_n = (int'(r_cnt) > MAX_WAYS) ? CNT_W'(MAX_WAYS) : r_cnt;

    n_valid = r_valid;
    n_cnt   = r_cnt;
    for (int i = 0; i < MAX_WAYS; i++) begin
      n_tag[i]  = r_tag[i];
      n_age[i]  = r_age[i];
      n_rtag[i] = r_rtag[i];
    end

    if (!flags.hit && admit) begin
      n_valid[touch_way] = 1'b1;
      n_tag[touch_way]   = tag_r;
    end
    if (do_touch) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (i < int'(ways_eff)) begin
          if (i == int'(touch_way)) begin
            n_age[i] = '0;
          end else if (r_age[i] != AGE_MAX) begin
            n_age[i] = r_age[i] + AGE_WIDTH'(1);
          end
        end
      end
    end

    // Recent-tag queue: remove a matched entry, or append the missing tag,
    // dropping the oldest when the queue is at capacity.
    if (!flags.hit && policy_r) begin
      if (flags.fifo_hit) begin
        for (int i = 0; i < MAX_WAYS - 1; i++) begin
          if (i >= int'(fifo_idx)) begin
            n_rtag[i] = r_rtag[i + 1];
          end
        end
        n_cnt = q_n - CNT_W'(1);
      end else if (q_n >= ways_eff) begin
        for (int i = 0; i < MAX_WAYS - 1; i++) begin
          n_rtag[i] = r_rtag[i + 1];
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
          if (i == int'(q_n) - 1) begin
            n_rtag[i] = tag_r;
          end
        end
        n_cnt = q_n;
      end else begin
        for (int i = 0; i < MAX_WAYS; i++) begin
          if (i == int'(q_n)) begin
            n_rtag[i] = tag_r;
          end
        end
        n_cnt = q_n + CNT_W'(1);
      end
    end

    new_row = '0;
    new_row[MAX_WAYS-1:0]     = n_valid;
    new_row[CNT_LO +: CNT_W]  = n_cnt;
    for (int i = 0; i < MAX_WAYS; i++) begin
      new_row[TAG_LO + i * ADDR_WIDTH +: ADDR_WIDTH] = n_tag[i];
      new_row[AGE_LO + i * AGE_WIDTH +: AGE_WIDTH]   = n_age[i];
      new_row[RTAG_LO + i * ADDR_WIDTH +: ADDR_WIDTH] = n_rtag[i];
    end

    if (mode_r == sacl_pkg::MODE_MODIFY) begin
      hits_now = flags.hit ? 2'd2 : 2'd1;
    end else begin
      hits_now = flags.hit ? 2'd1 : 2'd0;
    end
  end

  logic [TW:0] hits_sum, miss_sum, evict_sum;
  assign hits_sum  = {1'b0, total_hits_r} + (TW + 1)'(hits_now);
  assign miss_sum  = {1'b0, total_misses_r} + (TW + 1)'(!flags.hit);
  assign evict_sum = {1'b0, total_evicts_r} + (TW + 1)'(evict);

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLR;
      clr_idx_r      <= '0;
      out_valid_r    <= 1'b0;
      total_hits_r   <= '0;
      total_misses_r <= '0;
      total_evicts_r <= '0;
    end else begin
      if (out_valid_r && out_ready && !upd_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLR: begin
          clr_idx_r <= clr_idx_r + SET_AW'(1);
          if (clr_idx_r == SET_AW'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && in_mode != sacl_pkg::MODE_IFETCH) begin
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (upd_go) begin
            state_r        <= ST_IDLE;
            out_valid_r    <= 1'b1;
            total_hits_r   <= hits_sum[TW] ? '1 : hits_sum[TW-1:0];
            total_misses_r <= miss_sum[TW] ? '1 : miss_sum[TW-1:0];
            total_evicts_r <= evict_sum[TW] ? '1 : evict_sum[TW-1:0];
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      tag_r  <= in_tag;
      set_r  <= in_set;
    end
    if (upd_go) begin
      hits_added_r <= hits_now;
      missed_r     <= !flags.hit;
      evicted_r    <= evict;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hits_added      = hits_added_r;
  assign out_missed          = missed_r;
  assign out_evicted         = evicted_r;
  assign out_total_hits      = total_hits_r;
  assign out_total_misses    = total_misses_r;
  assign out_total_evictions = total_evicts_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "set_assoc_cache_lru_2q_unit_assert.svh"

  `SACL_ASSERT_SAME(a_evict_needs_miss, clk, rst_n, out_valid && out_evicted, out_missed)
  `SACL_ASSERT_SAME(a_double_hit_is_hit, clk, rst_n, out_valid && out_hits_added == 2'd2, !out_missed)
  `SACL_ASSERT_NEXT(a_data_access_searches, clk, rst_n, accept && in_mode != sacl_pkg::MODE_IFETCH, state_r == ST_CMP)
  `SACL_ASSERT_SAME(a_write_only_on_update, clk, rst_n, ram_we && state_r != ST_CLR, state_r == ST_UPD)

endmodule
`default_nettype wire

// ===== tb/set_assoc_cache_lru_2q_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Cache unit checker
// Watches the configuration port and both channels of the cache unit. It
// keeps its own copy of the cache lines, ages, recent-tag queues and totals,
// predicts the result beat of every accepted data access and compares each
// result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module set_assoc_cache_lru_2q_unit_checker
  import sacl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              in_mode,
  input  logic [ADDR_WIDTH-1:0]   in_address,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [1:0]              out_hits_added,
  input  logic                    out_missed,
  input  logic                    out_evicted,
  input  logic [TOTAL_W-1:0]      out_total_hits,
  input  logic [TOTAL_W-1:0]      out_total_misses,
  input  logic [TOTAL_W-1:0]      out_total_evictions,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  output int                      error_count,
  output int                      pending
);

  localparam int NSETS = 1 << MAX_SET_BITS;
  localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [1:0]         hits_added;
    logic               missed;
    logic               evicted;
    logic [TOTAL_W-1:0] total_hits;
    logic [TOTAL_W-1:0] total_misses;
    logic [TOTAL_W-1:0] total_evictions;
  } cache_result_t;

  logic                  line_ok  [NSETS][MAX_WAYS];
  logic [63:0]           line_tg  [NSETS][MAX_WAYS];
  logic [AGE_WIDTH-1:0]  line_ag  [NSETS][MAX_WAYS];
  logic [63:0]           recent_q [NSETS][MAX_WAYS];
  int                    recent_n [NSETS];
  logic [TOTAL_W-1:0]    hit_sum, miss_sum, evict_sum;
  logic [SET_BITS_W-1:0]   set_bits_r;
  logic [BLOCK_BITS_W-1:0] block_bits_r;
  logic [WAYS_W-1:0]       ways_r;
  logic                    policy_r;

  cache_result_t result_q[$];

  assign pending = result_q.size();

  function automatic logic [TOTAL_W-1:0] sat_inc(logic [TOTAL_W-1:0] a, int b);
    if (a > TOTAL_MAX - b) return TOTAL_MAX;
    return a + b;
  endfunction

  task automatic age_set(int s, int ways, int way);
    for (int i = 0; i < ways; i++) begin
      if (i == way) line_ag[s][i] = '0;
      else if (line_ag[s][i] < AGE_MAX) line_ag[s][i] = line_ag[s][i] + 1'b1;
    end
  endtask

  // Removes the first matching tag from the set's recent queue.
  task automatic recent_take(int s, logic [63:0] tag, output bit found);
    int n;
    n = (recent_n[s] > MAX_WAYS) ? MAX_WAYS : recent_n[s];
    found = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && recent_q[s][i] == tag) begin
        found = 1;
        for (int j = i; j < n - 1; j++) recent_q[s][j] = recent_q[s][j+1];
        recent_n[s] = n - 1;
      end
    end
  endtask

  task automatic recent_push(int s, logic [63:0] tag, int ways);
    int n;
    n = (recent_n[s] > MAX_WAYS) ? MAX_WAYS : recent_n[s];
    if (n >= ways) begin
      for (int j = 0; j < n - 1; j++) recent_q[s][j] = recent_q[s][j+1];
      n = (n > 0) ? n - 1 : 0;
    end
    recent_q[s][n] = tag;
    recent_n[s] = n + 1;
  endtask

  task automatic predict_access(mode_t mode, logic [63:0] addr);
    int sb, ways, s, way, empty_way, hits_now;
    bit hit, evict, admit, have_empty;
    logic [63:0] tag;
    cache_result_t r;
    sb = (set_bits_r > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_r;
    ways = (ways_r == 0) ? 1 : ((ways_r > MAX_WAYS) ? MAX_WAYS : ways_r);
    s = int'((addr >> block_bits_r) & ((64'd1 << sb) - 1));
    tag = addr >> (block_bits_r + sb);
    hit = 0; evict = 0; admit = 1; have_empty = 0; empty_way = 0;
    for (int i = 0; i < ways; i++) begin
      if (!hit) begin
        if (line_ok[s][i] && line_tg[s][i] == tag) begin
          hit = 1;
          age_set(s, ways, i);
        end else if (!line_ok[s][i] && !have_empty) begin
          have_empty = 1;
          empty_way = i;
        end
      end
    end
    if (!hit) begin
      if (policy_r) begin
        recent_take(s, tag, admit);
        if (!admit) recent_push(s, tag, ways);
      end
      if (admit) begin
        if (have_empty) begin
          way = empty_way;
        end else begin
          way = 0;
          for (int i = 1; i < ways; i++)
            if (line_ag[s][i] > line_ag[s][way]) way = i;
          evict = 1;
        end
        line_ok[s][way] = 1'b1;
        line_tg[s][way] = tag;
        age_set(s, ways, way);
      end
    end
    hits_now = (hit ? 1 : 0) + ((mode == MODE_MODIFY) ? 1 : 0);
    hit_sum = sat_inc(hit_sum, hits_now);
    if (!hit) miss_sum = sat_inc(miss_sum, 1);
    if (evict) evict_sum = sat_inc(evict_sum, 1);
    r.hits_added = hits_now[1:0];
    r.missed = !hit;
    r.evicted = evict;
    r.total_hits = hit_sum;
    r.total_misses = miss_sum;
    r.total_evictions = evict_sum;
    result_q.push_back(r);
  endtask

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin
    cache_result_t want;
    if (!rst_n) begin
      for (int s = 0; s < NSETS; s++) begin
        recent_n[s] = 0;
        for (int w = 0; w < MAX_WAYS; w++) begin
          line_ok[s][w] = 1'b0;
          line_ag[s][w] = '0;
        end
      end
      hit_sum = '0; miss_sum = '0; evict_sum = '0;
      set_bits_r = SET_BITS_RST;
      block_bits_r = BLOCK_BITS_RST;
      ways_r = WAYS_RST;
      policy_r = 1'b0;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SET_BITS:   set_bits_r = cfg_wdata[SET_BITS_W-1:0];
          CFG_BLOCK_BITS: block_bits_r = cfg_wdata[BLOCK_BITS_W-1:0];
          CFG_WAYS_USED:  ways_r = cfg_wdata[WAYS_W-1:0];
          CFG_POLICY:     policy_r = cfg_wdata[0];
        endcase
      end
      // Compare first: a result leaving on this edge belongs to an older access.
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result beat with no access outstanding", $time);
          error_count++;
        end else begin
          want = result_q.pop_front();
          if (out_hits_added !== want.hits_added)
            report("hits_added", want.hits_added, out_hits_added);
          if (out_missed !== want.missed) report("missed", want.missed, out_missed);
          if (out_evicted !== want.evicted) report("evicted", want.evicted, out_evicted);
          if (out_total_hits !== want.total_hits)
            report("total_hits", want.total_hits, out_total_hits);
          if (out_total_misses !== want.total_misses)
            report("total_misses", want.total_misses, out_total_misses);
          if (out_total_evictions !== want.total_evictions)
            report("total_evictions", want.total_evictions, out_total_evictions);
        end
      end
      if (in_valid && in_ready && mode_t'(in_mode) != MODE_IFETCH)
        predict_access(mode_t'(in_mode), in_address);
    end
  end

  initial error_count = 0;

endmodule

// ===== tb/set_assoc_cache_lru_2q_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Cache unit testbench
// Drives the cache unit through several register settings, each with a
// stream of accesses built around a small pool of tags and sets so that
// hits, evictions and queue admissions happen often. Both channels stall at
// random; a separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module set_assoc_cache_lru_2q_unit_tb;
  import sacl_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = MODE_LOAD;
  logic [ADDR_WIDTH-1:0] in_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_hits_added;
  logic out_missed, out_evicted;
  logic [TOTAL_W-1:0] out_total_hits, out_total_misses, out_total_evictions;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SET_BITS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int error_count, pending, idle_cycles;
  int cur_sb = 4, cur_bb = 4;
  bit send_burst = 0, recv_burst = 0;

  always #4 clk = ~clk;

  set_assoc_cache_lru_2q_unit DUT (.*);

  set_assoc_cache_lru_2q_unit_checker u_checker (.*);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls before each beat, with runs of no stalling.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) recv_burst = !recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Waits until every result has left, plus room for a trailing fetch.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic configure(int sb, int bb, int ways, int policy);
    write_reg(CFG_SET_BITS, sb);
    write_reg(CFG_BLOCK_BITS, bb);
    write_reg(CFG_WAYS_USED, ways);
    write_reg(CFG_POLICY, policy);
    cur_sb = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
    cur_bb = bb;
  endtask

  task automatic send_access(mode_t mode, logic [63:0] addr);
    int gap;
    if ($urandom_range(0, 7) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode = mode;
    in_address = addr;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [63:0] make_addr(logic [63:0] tag, int set_no);
    logic [63:0] off;
    off = {$urandom, $urandom} & ((64'd1 << cur_bb) - 1);
    return (tag << (cur_bb + cur_sb)) |
           ((64'(set_no) & ((64'd1 << cur_sb) - 1)) << cur_bb) | off;
  endfunction

  task automatic random_phase(int count);
    int pick;
    logic [63:0] addr;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) addr = {$urandom, $urandom};
      else if (pick == 1) addr = make_addr({$urandom, $urandom}, $urandom_range(0, 3));
      else addr = make_addr($urandom_range(0, 5), $urandom_range(0, 3));
      send_access(mode_t'($urandom_range(0, 3)), addr);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, every kind, 2Q rejection then admission, eviction.
    configure(2, 3, 2, 1);
    send_access(MODE_LOAD, 64'd0);
    send_access(MODE_IFETCH, 64'd0);
    send_access(MODE_LOAD, 64'd0);
    send_access(MODE_STORE, 64'd0);
    send_access(MODE_MODIFY, '1);
    send_access(MODE_MODIFY, '1);
    send_access(MODE_MODIFY, '1);
    send_access(MODE_LOAD, make_addr(1, 0));
    send_access(MODE_LOAD, make_addr(2, 0));
    send_access(MODE_LOAD, make_addr(3, 0));
    send_access(MODE_LOAD, make_addr(1, 0));
    send_access(MODE_LOAD, make_addr(3, 0));
    send_access(MODE_LOAD, make_addr(4, 0));
    send_access(MODE_LOAD, make_addr(4, 0));
    send_access(MODE_STORE, make_addr(2, 0));
    send_access(MODE_IFETCH, '1);
    drain();
    configure(0, 0, 1, 0);
    send_access(MODE_LOAD, 64'h5555_5555_5555_5555);
    send_access(MODE_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
    send_access(MODE_MODIFY, 64'h5555_5555_5555_5555);
    send_access(MODE_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
    random_phase(90);
    drain();

    configure(8, 16, 8, 1);
    random_phase(110);
    drain();
    configure(2, 3, 4, 1);
    random_phase(120);
    drain();
    configure(1, 5, 2, 0);
    random_phase(110);
    drain();
    configure(15, 31, 15, 1);
    random_phase(100);
    drain();
    configure(3, 2, 0, 1);
    random_phase(100);
    drain();
    // The way count grows here from one to three; earlier shrinking left overfull recent queues.
    configure(3, 2, 3, 1);
    random_phase(100);
    drain();
    configure(4, 4, 1, 0);
    random_phase(200);
    drain();

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
